### design/pms_pkg.sv
package pms_pkg;

  localparam int MAX_TASKS_DEF       = 16;
  localparam int PRIORITY_LEVELS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF     = 8;

  localparam int ENTRY_W = 24;
  localparam int MAP_W   = 48;
  localparam int CFG_W   = 48;

  localparam logic CMD_POST     = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic CFG_TASK_COUNT   = 1'b0;
  localparam logic CFG_PRIORITY_MAP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } pms_status_t;

  typedef struct packed {
    logic        dispatched;
    logic [2:0]  prio;
    pms_status_t status;
  } pms_result_t;

endpackage

### design/pms_queue_mem.sv
module pms_queue_mem import pms_pkg::*; #(
  parameter int DEPTH = PRIORITY_LEVELS_DEF * QUEUE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic               re,
  input  logic [AW-1:0]      addr,
  input  logic [ENTRY_W-1:0] wdata,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### design/pms_sched.sv
module pms_sched import pms_pkg::*; #(
  parameter int MAX_TASKS       = MAX_TASKS_DEF,
  parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
  parameter int AW = (PRIORITY_LEVELS * QUEUE_DEPTH > 1) ?
                     $clog2(PRIORITY_LEVELS * QUEUE_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               accept,
  input  logic               command,
  input  logic [3:0]         dest_task,
  input  logic [7:0]         signal_code,
  input  logic [7:0]         message_tag,
  input  logic               last_disp,
  input  logic [3:0]         last_dest,
  output logic               mem_we,
  output logic               mem_re,
  output logic [AW-1:0]      mem_addr,
  output logic [ENTRY_W-1:0] mem_wdata,
  output pms_result_t        res
);

  localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [4:0]       task_count;
  logic [MAP_W-1:0] priority_map;
  logic [QW-1:0]    head_index [PRIORITY_LEVELS];
  logic [CW-1:0]    fill_count [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] ready_mask;
  logic [3:0]       current_task;

  logic [4:0]    limit;
  logic [2:0]    map_pri;
  logic [LW-1:0] post_pri;
  logic [LW-1:0] disp_pri;
  logic          found;
  logic [LW-1:0] sel_pri;
  logic [QW-1:0] head_sel;
  logic [CW-1:0] fill_sel;
  logic [CW:0]   tail_sum;
  logic [QW-1:0] tail;
  logic [QW-1:0] head_inc;
  logic          do_write;
  logic          do_pop;
  logic [3:0]    current_eff;

  always_comb begin
    limit    = (task_count > 5'(MAX_TASKS)) ? 5'(MAX_TASKS) : task_count;
    map_pri  = priority_map[3*dest_task +: 3];
    post_pri = (4'(map_pri) >= 4'(PRIORITY_LEVELS)) ? LW'(PRIORITY_LEVELS - 1)
                                                    : LW'(map_pri);
    found    = 1'b0;
    disp_pri = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      if (ready_mask[i]) begin
        found    = 1'b1;
        disp_pri = LW'(i);
      end
    end
    sel_pri  = (command == CMD_DISPATCH) ? disp_pri : post_pri;
    head_sel = head_index[sel_pri];
    fill_sel = fill_count[sel_pri];
    tail_sum = (CW+1)'(head_sel) + (CW+1)'(fill_sel);
    tail     = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ? QW'(tail_sum - (CW+1)'(QUEUE_DEPTH))
                                                  : QW'(tail_sum);
    head_inc = ((QW+1)'(head_sel) + 1'b1 == (QW+1)'(QUEUE_DEPTH)) ? '0 : QW'(head_sel + 1'b1);
    current_eff = last_disp ? last_dest : current_task;

    do_write   = 1'b0;
    do_pop     = 1'b0;
    res.dispatched = 1'b0;
    res.prio   = '0;
    res.status = ST_OK;
    if (command == CMD_DISPATCH) begin
      if (!found || fill_sel == '0) begin
        res.status = ST_EMPTY;
      end else begin
        do_pop         = 1'b1;
        res.dispatched = 1'b1;
        res.prio       = 3'(sel_pri);
      end
    end else begin
      if ({1'b0, dest_task} >= limit) begin
        res.status = ST_UNKNOWN;
      end else if (fill_sel >= CW'(QUEUE_DEPTH)) begin
        res.status = ST_FULL;
      end else begin
        do_write = 1'b1;
      end
    end

    mem_we    = accept && do_write;
    mem_re    = accept && do_pop;
    mem_addr  = AW'(int'(sel_pri) * QUEUE_DEPTH +
                    int'((command == CMD_DISPATCH) ? head_sel : tail));
    mem_wdata = {current_eff, dest_task, signal_code, message_tag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count   <= '0;
      priority_map <= '0;
      ready_mask   <= '0;
      current_task <= '0;
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head_index[i] <= '0;
        fill_count[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TASK_COUNT:   task_count   <= cfg_data[4:0];
          CFG_PRIORITY_MAP: priority_map <= cfg_data[MAP_W-1:0];
        endcase
      end
      current_task <= current_eff;
      if (mem_we) begin
        fill_count[sel_pri] <= fill_sel + 1'b1;
        ready_mask[sel_pri] <= 1'b1;
      end
      if (mem_re) begin
        head_index[sel_pri] <= head_inc;
        fill_count[sel_pri] <= fill_sel - 1'b1;
        if (fill_sel == CW'(1)) begin
          ready_mask[sel_pri] <= 1'b0;
        end
      end
    end
  end

endmodule

### design/priority_message_scheduler.sv
// The result strobe comes in the cycle after the command transfer.
// Throughput: one command per cycle; the single-port queue memory is read
// or written at most once per command; read data lands in the result stage.
// Reset (rst, synchronous): clears counters, heads, ready mask, current task
// and config; queue memory contents are not cleared. busy is high in reset.
// Results are not back-pressured: result_valid is high for one cycle only.
module priority_message_scheduler import pms_pkg::*; #(
  parameter int MAX_TASKS       = MAX_TASKS_DEF,
  parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             start,
  output logic             busy,
  input  logic             command,
  input  logic [3:0]       dest_task,
  input  logic [7:0]       signal_code,
  input  logic [7:0]       message_tag,
  output logic             result_valid,
  output logic             dispatched,
  output logic [3:0]       out_task,
  output logic [3:0]       out_source,
  output logic [7:0]       out_signal,
  output logic [7:0]       out_message,
  output logic [2:0]       out_priority,
  output logic [1:0]       status
);

  localparam int DEPTH = PRIORITY_LEVELS * QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic               accept;
  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  pms_result_t        res_next;
  pms_result_t        res;
  logic               valid;

  assign busy   = rst;
  assign accept = start && !busy;

  pms_sched #(
    .MAX_TASKS      (MAX_TASKS),
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .AW             (AW)
  ) u_sched (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .command    (command),
    .dest_task  (dest_task),
    .signal_code(signal_code),
    .message_tag(message_tag),
    .last_disp  (valid && res.dispatched),
    .last_dest  (mem_rdata[19:16]),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .res        (res_next)
  );

  pms_queue_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      res.dispatched <= 1'b0;
    end else begin
      valid <= accept;
      if (accept) begin
        res <= res_next;
      end
    end
  end

  assign result_valid = valid;
  assign dispatched   = res.dispatched;
  assign out_task     = res.dispatched ? mem_rdata[19:16] : '0;
  assign out_source   = res.dispatched ? mem_rdata[23:20] : '0;
  assign out_signal   = res.dispatched ? mem_rdata[15:8]  : '0;
  assign out_message  = res.dispatched ? mem_rdata[7:0]   : '0;
  assign out_priority = res.prio;
  assign status       = res.status;

endmodule

### design/pms_checker.sv
module pms_checker import pms_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       command,
  input logic       result_valid,
  input logic       dispatched,
  input logic [3:0] out_task,
  input logic [3:0] out_source,
  input logic [7:0] out_signal,
  input logic [7:0] out_message,
  input logic [2:0] out_priority,
  input logic [1:0] status
);

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> result_valid)
    else $error("command transfer without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy))
    else $error("result without command");

  a_disp_cmd: assert property (@(posedge clk) disable iff (rst)
    result_valid && dispatched |-> $past(command) == CMD_DISPATCH && status == ST_OK)
    else $error("dispatch result from wrong command or bad status");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && !dispatched |-> out_task == 4'd0 && out_source == 4'd0 &&
      out_signal == 8'd0 && out_message == 8'd0 && out_priority == 3'd0)
    else $error("nonzero fields on non-dispatch result");

endmodule

bind priority_message_scheduler pms_checker u_pms_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .command     (command),
  .result_valid(result_valid),
  .dispatched  (dispatched),
  .out_task    (out_task),
  .out_source  (out_source),
  .out_signal  (out_signal),
  .out_message (out_message),
  .out_priority(out_priority),
  .status      (status)
);
